// ===== design/vllc_pkg.sv =====
// ----------------------------------------------------------------------------
// vllc_pkg
// Shared types, constants and codes for the line layer compositor.
// ----------------------------------------------------------------------------
package vllc_pkg;

	// Framebuffer geometry: two banks of 2^BANK_ADDR_BITS words
	localparam int BANK_ADDR_BITS = 16;
	localparam int FB_ADDR_W      = BANK_ADDR_BITS + 1;
	localparam int PTR_W          = BANK_ADDR_BITS + 2;
	localparam int FB_DEPTH       = 1 << FB_ADDR_W;

	localparam int PAL_ADDR_W = 8;
	localparam int PAL_DEPTH  = 1 << PAL_ADDR_W;

	localparam int WORD_W    = 16;
	localparam int CFG_W     = 4;
	localparam int MODE_W    = 3;
	localparam int INVERT_BIT = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_FB_WRITE   = 2'd0,
		ACT_PAL_WRITE  = 2'd1,
		ACT_LINE_START = 2'd2,
		ACT_PIXEL      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_BLANK  = 2'd0,
		MODE_PACKED = 2'd1,
		MODE_DIRECT = 2'd2,
		MODE_RUN    = 2'd3
	} mode_t;

	localparam logic [1:0] SRC_BASE    = 2'd0;
	localparam logic [1:0] SRC_PALETTE = 2'd1;
	localparam logic [1:0] SRC_DIRECT  = 2'd2;

	typedef struct packed {
		action_t     action;
		logic        bank;
		logic [7:0]  line;
		logic [15:0] address;
		logic [15:0] data;
		logic [7:0]  palette_index;
		logic [7:0]  base_pixel;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  source;
		logic [15:0] colour;
	} out_item_t;

	// Classified command handed from the front to the back
	typedef struct packed {
		action_t                op;
		logic [FB_ADDR_W-1:0]   fb_addr;
		logic [WORD_W-1:0]      data;
		logic [PAL_ADDR_W-1:0]  pal_idx;
		logic [7:0]             base;
	} cmd_t;

endpackage

// ===== design/vllc_front.sv =====
// ----------------------------------------------------------------------------
// vllc_front
// Accept input beats and turn them into framebuffer-addressed commands.
// ----------------------------------------------------------------------------
module vllc_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  vllc_pkg::in_item_t in_item,
	input  logic               queue_full,
	output logic               push,
	output vllc_pkg::cmd_t     cmd
);

	localparam int BAB = vllc_pkg::BANK_ADDR_BITS;

	logic [BAB-1:0] line_word;

	assign in_ready  = !queue_full;
	assign push      = in_valid && !queue_full;
	assign line_word = BAB'(in_item.line);

	always_comb begin
		cmd.op      = in_item.action;
		cmd.data    = in_item.data;
		cmd.pal_idx = in_item.palette_index;
		cmd.base    = in_item.base_pixel;
		// line start addresses the line table, writes address the bank
		if (in_item.action == vllc_pkg::ACT_LINE_START) begin
			cmd.fb_addr = {in_item.bank, line_word};
		end else begin
			cmd.fb_addr = {in_item.bank, in_item.address[BAB-1:0]};
		end
	end

endmodule

// ===== design/vllc_queue.sv =====
// ----------------------------------------------------------------------------
// vllc_queue
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module vllc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vllc_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output vllc_pkg::cmd_t head_cmd
);

	localparam int DEPTH = vllc_pkg::QUEUE_DEPTH;
	localparam int PW    = vllc_pkg::QUEUE_PTR_W;
	localparam int CW    = vllc_pkg::QUEUE_CNT_W;

	vllc_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== design/vllc_back.sv =====
// ----------------------------------------------------------------------------
// vllc_back
// Execute commands: framebuffer and palette access, pointer and run state,
// layer selection and the output register.
// ----------------------------------------------------------------------------
module vllc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vllc_pkg::cmd_t                  cmd,
	input  logic                            cmd_valid,
	output logic                            cmd_pop,
	input  logic [vllc_pkg::MODE_W-1:0]     render_mode,
	output logic                            out_valid,
	input  logic                            out_ready,
	output vllc_pkg::out_item_t             out_item
);

	localparam int BAB = vllc_pkg::BANK_ADDR_BITS;
	localparam int FAW = vllc_pkg::FB_ADDR_W;
	localparam int PW  = vllc_pkg::PTR_W;
	localparam int WW  = vllc_pkg::WORD_W;
	localparam int PAW = vllc_pkg::PAL_ADDR_W;

	// memories
	logic [WW-1:0] fb_mem  [vllc_pkg::FB_DEPTH];
	logic [WW-1:0] pal_mem [vllc_pkg::PAL_DEPTH];

	// architectural state
	logic [PW-1:0]  ptr_q;
	logic [7:0]     run_left_q;
	logic [7:0]     run_colour_q;

	// issue stage signals
	logic           adv;
	logic           pop;
	vllc_pkg::mode_t mode_a;
	logic           fb_we;
	logic           fb_re;
	logic [FAW-1:0] fb_addr;
	logic [PW-1:0]  ptr_eff;
	logic [PW-1:0]  ptr_next;
	logic [7:0]     run_left_eff;
	logic [7:0]     run_left_next;
	logic [7:0]     run_colour_eff;
	logic [FAW-1:0] start_word;
	logic           pix_a;
	logic           fetch_a;
	logic           start_a;
	logic           pal_we;

	// stage 1
	logic            pix_s1;
	logic            fetch_s1;
	logic            start_s1;
	logic            start_bank_s1;
	vllc_pkg::mode_t mode_s1;
	logic            invert_s1;
	logic            byte_lo_s1;
	logic [7:0]      cidx_s1;
	logic [7:0]      base_s1;
	logic [WW-1:0]   fb_rd_s1;
	logic [PAW-1:0]  pal_addr;
	logic            pal_re;

	// stage 2
	logic            pix_s2;
	vllc_pkg::mode_t mode_s2;
	logic            invert_s2;
	logic [7:0]      base_s2;
	logic [WW-1:0]   dir_s2;
	logic [WW-1:0]   pal_rd_s2;
	logic            opaque;
	logic            take;
	vllc_pkg::out_item_t result;

	// output register
	logic                out_valid_q;
	vllc_pkg::out_item_t out_item_q;

	assign adv     = !out_valid_q || out_ready;
	assign pop     = adv && cmd_valid;
	assign cmd_pop = pop;
	assign mode_a  = vllc_pkg::mode_t'(render_mode[1:0]);

	// Forward state that is still sitting in the read data of stage 1
	assign start_word     = {start_bank_s1, {BAB{1'b0}}} + FAW'(fb_rd_s1);
	assign ptr_eff        = start_s1 ? {start_word, 1'b0} : ptr_q;
	assign run_left_eff   = fetch_s1 ? fb_rd_s1[15:8] : run_left_q;
	assign run_colour_eff = fetch_s1 ? fb_rd_s1[7:0] : run_colour_q;

	always_comb begin
		fb_we         = 1'b0;
		fb_re         = 1'b0;
		pal_we        = 1'b0;
		fb_addr       = cmd.fb_addr;
		ptr_next      = ptr_eff;
		run_left_next = run_left_eff;
		pix_a         = 1'b0;
		fetch_a       = 1'b0;
		start_a       = 1'b0;
		if (pop) begin
			unique case (cmd.op)
				vllc_pkg::ACT_FB_WRITE: begin
					fb_we = 1'b1;
				end
				vllc_pkg::ACT_PAL_WRITE: begin
					pal_we = 1'b1;
				end
				vllc_pkg::ACT_LINE_START: begin
					fb_re         = 1'b1;
					start_a       = 1'b1;
					run_left_next = '0;
				end
				vllc_pkg::ACT_PIXEL: begin
					pix_a   = 1'b1;
					fb_addr = ptr_eff[PW-1:1];
					unique case (mode_a)
						vllc_pkg::MODE_BLANK: begin
						end
						vllc_pkg::MODE_PACKED: begin
							fb_re    = 1'b1;
							ptr_next = ptr_eff + PW'(1);
						end
						vllc_pkg::MODE_DIRECT: begin
							fb_re    = 1'b1;
							ptr_next = ptr_eff + PW'(2);
						end
						vllc_pkg::MODE_RUN: begin
							if (run_left_eff == '0) begin
								fb_re    = 1'b1;
								fetch_a  = 1'b1;
								ptr_next = ptr_eff + PW'(2);
							end else begin
								run_left_next = run_left_eff - 8'd1;
							end
						end
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			run_left_q   <= '0;
			run_colour_q <= '0;
			pix_s1       <= 1'b0;
			fetch_s1     <= 1'b0;
			start_s1     <= 1'b0;
			pix_s2       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			ptr_q        <= ptr_next;
			run_left_q   <= run_left_next;
			run_colour_q <= run_colour_eff;
			pix_s1       <= pix_a;
			fetch_s1     <= fetch_a;
			start_s1     <= start_a;
			pix_s2       <= pix_s1;
			out_valid_q  <= pix_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			start_bank_s1 <= cmd.fb_addr[FAW-1];
			mode_s1       <= mode_a;
			invert_s1     <= render_mode[vllc_pkg::INVERT_BIT];
			byte_lo_s1    <= ptr_eff[0];
			cidx_s1       <= run_colour_eff;
			base_s1       <= cmd.base;
			mode_s2       <= mode_s1;
			invert_s2     <= invert_s1;
			base_s2       <= base_s1;
			dir_s2        <= fb_rd_s1;
			out_item_q    <= result;
		end
	end

	// Framebuffer: one port, write or read per cycle
	always_ff @(posedge clk) begin
		if (fb_we) begin
			fb_mem[fb_addr] <= cmd.data;
		end
		if (fb_re) begin
			fb_rd_s1 <= fb_mem[fb_addr];
		end
	end

	// Palette lookup index: byte of the packed word, or run colour
	always_comb begin
		if (mode_s1 == vllc_pkg::MODE_PACKED) begin
			pal_addr = byte_lo_s1 ? fb_rd_s1[7:0] : fb_rd_s1[15:8];
		end else begin
			pal_addr = fetch_s1 ? fb_rd_s1[7:0] : cidx_s1;
		end
	end

	assign pal_re = adv && pix_s1 &&
		(mode_s1 == vllc_pkg::MODE_PACKED || mode_s1 == vllc_pkg::MODE_RUN);

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[cmd.pal_idx] <= cmd.data;
		end
		if (pal_re) begin
			pal_rd_s2 <= pal_mem[pal_addr];
		end
	end

	// Layer selection
	assign opaque = (base_s2[3:0] != 4'd0);

	always_comb begin
		result.source = vllc_pkg::SRC_BASE;
		result.colour = WW'(base_s2);
		take          = 1'b0;
		unique case (mode_s2)
			vllc_pkg::MODE_BLANK: begin
			end
			vllc_pkg::MODE_PACKED: begin
				take = invert_s2 ? !(pal_rd_s2[15] && opaque) : (pal_rd_s2[15] || !opaque);
				if (take) begin
					result.source = vllc_pkg::SRC_PALETTE;
					result.colour = pal_rd_s2;
				end
			end
			vllc_pkg::MODE_DIRECT: begin
				take = invert_s2 ? (!dir_s2[15] && opaque) : (dir_s2[15] || !opaque);
				if (take) begin
					result.source = vllc_pkg::SRC_DIRECT;
					result.colour = dir_s2;
				end
			end
			vllc_pkg::MODE_RUN: begin
				result.source = vllc_pkg::SRC_PALETTE;
				result.colour = pal_rd_s2;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// A line start and a run fetch are different commands in stage 1
	a_fwd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(start_s1 && fetch_s1))
		else $error("line start and run fetch both pending in stage 1");

	a_fb_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(fb_we && fb_re))
		else $error("framebuffer written and read in one cycle");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ptr_q) && $stable(run_left_q) && $stable(pix_s2))
		else $error("back state moved while stalled");

	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cmd.op == vllc_pkg::ACT_LINE_START) |=> (run_left_q == '0))
		else $error("line start did not cut off the run");

	a_pal_feed: assert property (@(posedge clk) disable iff (!arst_n)
		pal_re |=> pix_s2)
		else $error("palette read without a pixel behind it");

endmodule

// ===== design/video_line_layer_compositor_unit.sv =====
// ----------------------------------------------------------------------------
// video_line_layer_compositor_unit
// Line compositor: framebuffer and palette writes, line start, and one
// composited pixel for each base-layer pixel.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_item carry one beat per command: framebuffer write,
//   palette write, line start or base pixel. Only a base pixel yields a
//   beat on out_valid/out_ready/out_item (source and raw colour code).
//   cfg_we/cfg_wdata load render_mode; write it only while the block is
//   idle.
// Throughput: one beat per cycle in every mode unless the output stalls,
//   including a line start directly followed by pixels and back-to-back
//   run-length fetches; the read pointer and run count are forwarded from
//   the framebuffer read data. A pixel passes the queue, framebuffer read,
//   palette read and output register in that order before out_valid.
// Stall: while out_valid is high and out_ready low the whole back end holds;
//   the two-entry command queue keeps taking beats until full, then
//   in_ready drops. in_ready depends on the queue fill only.
// Reset: arst_n clears pointer, run state, render_mode and all valids. The
//   framebuffer and palette are not cleared; load them before use.
// ----------------------------------------------------------------------------
module video_line_layer_compositor_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  vllc_pkg::in_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output vllc_pkg::out_item_t          out_item,
	input  logic                         cfg_we,
	input  logic [vllc_pkg::CFG_W-1:0]   cfg_wdata
);

	// render_mode: bits 1:0 mode, bit 2 priority inversion, bit 3 unused
	logic [vllc_pkg::CFG_W-1:0] render_mode_q;

	logic           push;
	logic           queue_full;
	vllc_pkg::cmd_t front_cmd;
	logic           head_valid;
	vllc_pkg::cmd_t head_cmd;
	logic           pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			render_mode_q <= '0;
		end else if (cfg_we) begin
			render_mode_q <= cfg_wdata;
		end
	end

	// Front: take the beat, classify it, compute its framebuffer address
	vllc_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.queue_full (queue_full),
		.push       (push),
		.cmd        (front_cmd)
	);

	// Queue: lets the front keep accepting while the back is stalled
	vllc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (front_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Back: memories, pointer and run state, layer choice, output register
	vllc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (head_cmd),
		.cmd_valid   (head_valid),
		.cmd_pop     (pop),
		.render_mode (render_mode_q[vllc_pkg::MODE_W-1:0]),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

endmodule
